@@ src/lrus_pkg.sv @@
// Shared types and constants for the LRU way selector with access counters.
`default_nettype none
package lrus_pkg;

  localparam int WAYS       = 16;
  localparam int COUNT_BITS = 32;
  localparam int WAY_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int MASK_BITS  = 16;
  localparam int FIELD_BITS = 32;
  localparam int CNT_WORD   = 4 * COUNT_BITS;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_STORE = 2'd1,
    OP_OTHER = 2'd2,
    OP_MISS  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [3:0]           hit_way;
    logic [MASK_BITS-1:0] valid_mask;
    logic [MASK_BITS-1:0] eligible_mask;
  } req_t;

  typedef struct packed {
    logic [3:0]            chosen_way;
    logic [FIELD_BITS-1:0] load_count;
    logic [FIELD_BITS-1:0] store_count;
    logic [FIELD_BITS-1:0] insert_count;
    logic [FIELD_BITS-1:0] write_count;
  } rsp_t;

  // One counter memory word holds all four counters of a way.
  typedef struct packed {
    logic [COUNT_BITS-1:0] writes;
    logic [COUNT_BITS-1:0] inserts;
    logic [COUNT_BITS-1:0] stores;
    logic [COUNT_BITS-1:0] loads;
  } cnt_t;

  typedef logic [WAYS-1:0][WAY_BITS-1:0] age_vec_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

endpackage
`default_nettype wire

@@ src/lru_way_select_with_access_counters.sv @@
// Top level: true-LRU way selection for one set with per-way saturating access counters.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   lrus_pkg::req_t (opcode, hit_way, masks)
//   rsp      out        rsp_valid/rsp_ready   lrus_pkg::rsp_t (chosen_way, four counts)
//
// On accept the block picks the way and reads its counter word from the counter RAM;
// in the write-back state it increments, writes back and ages the set.
// A request is taken while an earlier result still waits in the output register;
// the write-back cycle holds until that register is free.
// Reset sets way i to age i and clears all counters through per-way valid bits;
// no clearing pass is needed.
`default_nettype none
module lru_way_select_with_access_counters (
  input  wire  logic            clk,
  input  wire  logic            rst,
  input  wire  logic            req_valid,
  output logic                  req_ready,
  input  wire  lrus_pkg::req_t  req,
  output logic                  rsp_valid,
  input  wire  logic            rsp_ready,
  output lrus_pkg::rsp_t        rsp
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RMW  = 2'b10
  } state_t;

  state_t                          state;
  state_t                          state_next;
  lrus_pkg::age_vec_t              ages;
  lrus_pkg::age_vec_t              ages_next;
  logic [lrus_pkg::WAYS-1:0]       cnt_valid;
  logic [lrus_pkg::WAY_BITS-1:0]   way;
  logic [3:0]                      hit_raw;
  logic [1:0]                      op;
  logic                            oor;
  logic [lrus_pkg::WAY_BITS-1:0]   victim;
  logic [lrus_pkg::WAY_BITS-1:0]   sel_way;
  logic                            accept;
  logic                            done;
  logic                            mem_we;
  logic [lrus_pkg::CNT_WORD-1:0]   mem_rdata;
  lrus_pkg::cnt_t                  cur;
  lrus_pkg::cnt_t                  upd;
  logic [lrus_pkg::WAY_BITS-1:0]   age_w;
  logic [lrus_pkg::WAYS-1:0]       age_seen;

  lrus_victim u_victim (
    .ages          (ages),
    .valid_mask    (req.valid_mask),
    .eligible_mask (req.eligible_mask),
    .victim        (victim)
  );

  lrus_ram #(
    .WIDTH (lrus_pkg::CNT_WORD),
    .DEPTH (lrus_pkg::WAYS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (way),
    .wdata (upd),
    .re    (accept),
    .raddr (sel_way),
    .rdata (mem_rdata)
  );

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign done      = (state == S_RMW) && (!rsp_valid || rsp_ready);
  assign mem_we    = done && !oor;
  assign sel_way   = (req.opcode == lrus_pkg::OP_MISS) ? victim
                                                       : lrus_pkg::WAY_BITS'(req.hit_way);

  // Never-written entries read as zero.
  assign cur = cnt_valid[way] ? lrus_pkg::cnt_t'(mem_rdata) : '0;

  always_comb begin
    upd = cur;
    case (op)
      lrus_pkg::OP_LOAD: begin
        upd.loads = lrus_pkg::sat_inc(cur.loads);
      end
      lrus_pkg::OP_STORE: begin
        upd.stores = lrus_pkg::sat_inc(cur.stores);
        upd.writes = lrus_pkg::sat_inc(cur.writes);
      end
      lrus_pkg::OP_MISS: begin
        upd.inserts = lrus_pkg::sat_inc(cur.inserts);
        upd.writes  = lrus_pkg::sat_inc(cur.writes);
      end
      default: begin
        upd = cur;
      end
    endcase
  end

  // Make the chosen way MRU: younger ways age by one.
  assign age_w = ages[way];
  always_comb begin
    for (int i = 0; i < lrus_pkg::WAYS; i++) begin
      if (lrus_pkg::WAY_BITS'(i) == way) begin
        ages_next[i] = '0;
      end else if (ages[i] < age_w) begin
        ages_next[i] = ages[i] + lrus_pkg::WAY_BITS'(1);
      end else begin
        ages_next[i] = ages[i];
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_RMW;
        end
      end
      S_RMW: begin
        if (done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      cnt_valid <= '0;
      for (int i = 0; i < lrus_pkg::WAYS; i++) begin
        ages[i] <= lrus_pkg::WAY_BITS'(i);
      end
    end else begin
      state <= state_next;
      if (done) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (mem_we) begin
        cnt_valid[way] <= 1'b1;
        ages           <= ages_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      way     <= sel_way;
      hit_raw <= req.hit_way;
      op      <= req.opcode;
      oor     <= (req.opcode != lrus_pkg::OP_MISS) &&
                 (32'(req.hit_way) >= 32'(lrus_pkg::WAYS));
    end
    if (done) begin
      if (oor) begin
        rsp.chosen_way   <= hit_raw;
        rsp.load_count   <= '0;
        rsp.store_count  <= '0;
        rsp.insert_count <= '0;
        rsp.write_count  <= '0;
      end else begin
        rsp.chosen_way   <= 4'(way);
        rsp.load_count   <= lrus_pkg::FIELD_BITS'(upd.loads);
        rsp.store_count  <= lrus_pkg::FIELD_BITS'(upd.stores);
        rsp.insert_count <= lrus_pkg::FIELD_BITS'(upd.inserts);
        rsp.write_count  <= lrus_pkg::FIELD_BITS'(upd.writes);
      end
    end
  end

  always_comb begin
    age_seen = '0;
    for (int i = 0; i < lrus_pkg::WAYS; i++) begin
      age_seen[ages[i]] = 1'b1;
    end
  end

  a_age_perm: assert property (@(posedge clk) disable iff (rst)
    $countones(age_seen) == lrus_pkg::WAYS)
    else $error("way ages are no longer a permutation");

  a_accept_rmw: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_RMW))
    else $error("accepted request did not enter write-back");

  a_done_rsp: assert property (@(posedge clk) disable iff (rst)
    done |=> rsp_valid)
    else $error("write-back finished without a result");

  a_we_rmw: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state == S_RMW) && !accept))
    else $error("counter write outside write-back");

endmodule
`default_nettype wire

@@ src/lrus_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module lrus_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire  logic                             clk,
  input  wire  logic                             we,
  input  wire  logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire  logic [WIDTH-1:0]                 wdata,
  input  wire  logic                             re,
  input  wire  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic       [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ src/lrus_victim.sv @@
// Victim choice on a miss: first invalid way, else oldest eligible way of nonzero age, else way 0.
`default_nettype none
module lrus_victim (
  input  wire  lrus_pkg::age_vec_t                 ages,
  input  wire  logic [lrus_pkg::MASK_BITS-1:0]     valid_mask,
  input  wire  logic [lrus_pkg::MASK_BITS-1:0]     eligible_mask,
  output logic       [lrus_pkg::WAY_BITS-1:0]      victim
);

  localparam int LEAVES = 1 << lrus_pkg::WAY_BITS;
  localparam int LVLS   = lrus_pkg::WAY_BITS;

  logic [lrus_pkg::WAYS-1:0]     valid_w;
  logic [lrus_pkg::WAYS-1:0]     elig_w;
  logic [lrus_pkg::WAY_BITS-1:0] inv_way;
  logic                          inv_found;
  logic [lrus_pkg::WAY_BITS:0]   key [LVLS+1][LEAVES];
  logic [lrus_pkg::WAY_BITS-1:0] idx [LVLS+1][LEAVES];

  // Mask bits past the last way are dropped; ways past the mask read as invalid.
  assign valid_w = lrus_pkg::WAYS'({{lrus_pkg::WAYS{1'b0}}, valid_mask});
  assign elig_w  = lrus_pkg::WAYS'({{lrus_pkg::WAYS{1'b0}}, eligible_mask});

  always_comb begin
    inv_way   = '0;
    inv_found = 1'b0;
    for (int i = lrus_pkg::WAYS - 1; i >= 0; i--) begin
      if (!valid_w[i]) begin
        inv_way   = lrus_pkg::WAY_BITS'(i);
        inv_found = 1'b1;
      end
    end
  end

  // Max tree on {qualifies, age}; a tie keeps the left, lower-numbered way.
  always_comb begin
    for (int l = 0; l <= LVLS; l++) begin
      for (int j = 0; j < LEAVES; j++) begin
        key[l][j] = '0;
        idx[l][j] = '0;
      end
    end
    for (int j = 0; j < LEAVES; j++) begin
      idx[0][j] = lrus_pkg::WAY_BITS'(j);
      if (j < lrus_pkg::WAYS) begin
        if (elig_w[j] && (ages[j] != '0)) begin
          key[0][j] = {1'b1, ages[j]};
        end
      end
    end
    for (int l = 0; l < LVLS; l++) begin
      for (int j = 0; j < (LEAVES >> (l + 1)); j++) begin
        if (key[l][2*j+1] > key[l][2*j]) begin
          key[l+1][j] = key[l][2*j+1];
          idx[l+1][j] = idx[l][2*j+1];
        end else begin
          key[l+1][j] = key[l][2*j];
          idx[l+1][j] = idx[l][2*j];
        end
      end
    end
  end

  always_comb begin
    if (inv_found) begin
      victim = inv_way;
    end else if (key[LVLS][0][lrus_pkg::WAY_BITS]) begin
      victim = idx[LVLS][0];
    end else begin
      victim = '0;
    end
  end

endmodule
`default_nettype wire
